/* sv/ple_pkg.sv */
package ple_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MAX    = 3'd2,
    OP_DUMP   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_FULL   = 2'd2,
    STS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_ROTATE = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        result_position;
    logic signed [VAL_W-1:0] result_value;
    logic [POS_W-1:0]        element_count;
    logic                    last;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t              mode;
    logic [POS_W-1:0]        slot;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  function automatic out_item_t make_out(status_t sts, logic [POS_W-1:0] pos,
                                         logic signed [VAL_W-1:0] val,
                                         logic [POS_W-1:0] cnt, logic fin);
    out_item_t o;
    o.status          = sts;
    o.result_position = pos;
    o.result_value    = val;
    o.element_count   = cnt;
    o.last            = fin;
    return o;
  endfunction

endpackage

/* sv/ple_cell.sv */
module ple_cell import ple_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] left_d,
  input  logic signed [VAL_W-1:0] right_d,
  output logic signed [VAL_W-1:0] data_q
);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic [POS_W-1:0]        my_idx;

  assign my_idx = POS_W'(IDX);
  assign data_q = data_r;

  // Insert opens a gap at the slot, remove closes it, rotate moves every
  // entry one cell toward the head with the head wrapping to the tail.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.mode)
      CM_INSERT: begin
        if (my_idx == ctrl.slot) begin
          data_nxt = ctrl.value;
        end else if (my_idx > ctrl.slot) begin
          data_nxt = left_d;
        end
      end
      CM_REMOVE: begin
        if (my_idx >= ctrl.slot) begin
          data_nxt = right_d;
        end
      end
      CM_ROTATE: data_nxt = right_d;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* sv/positional_list_engine.sv */
// Positional list engine: an ordered list of up to DEPTH signed Q16.16
// values held in a chain of identical cells, one entry per cell, addressed
// by 1-based position. Insert, remove, clear and every error answer are
// decided in the cycle the item is accepted, with the single result item
// registered on the next edge. Find maximum and dump walk the chain: all
// cells rotate one place toward the head per cycle while the head cell is
// read, except that a dump's walk waits while the output side stalls one
// of its results, and a full turn of DEPTH places returns the list to its
// original order. A new item is taken when the walk is not running and the
// output register is empty or being emptied in the same cycle. Entries
// beyond the element count hold no meaningful data and are never reported.
// With DEPTH of 64 a full list reports an element count of zero in the
// six-bit field.
module positional_list_engine import ple_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic                    is_dump_r, is_dump_nxt;
  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic signed [VAL_W-1:0] cell_q [DEPTH];
  cell_ctrl_t              ctrl;

  logic                    accept;
  logic                    out_free;
  logic [POS_W-1:0]        pos_m1;
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  logic                    list_full;
  logic                    list_empty;
  logic                    scan_op;
  logic                    in_range;
  logic                    advance;
  logic                    scan_done;
  logic [CNT_W-1:0]        k_ext;

  // The output register may take a new item when it is empty or its
  // current item leaves at this edge.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign pos_m1     = in_item.position - 1'b1;
  assign pos_c      = CMP_W'(in_item.position);
  assign cnt_c      = CMP_W'(count_r);
  assign list_full  = (cnt_c >= CMP_W'(DEPTH));
  assign list_empty = (count_r == '0);
  assign scan_op    = (in_item.opcode == OP_MAX) || (in_item.opcode == OP_DUMP);

  // During a walk the head cell holds the element at list index k_r.
  assign k_ext     = CNT_W'(k_r);
  assign in_range  = (k_ext < count_r);
  assign advance   = !(is_dump_r && in_range) || out_free;
  assign scan_done = advance && (k_r == IDX_W'(DEPTH - 1));

  // The chain of cells. Cell 0 is the head of the list; the tail cell's
  // right neighbor is the head, which closes the ring for rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    if (i == 0) begin : g_head
      assign left_d = ctrl.value;
    end else begin : g_body
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = cell_q[0];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[i])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && scan_op && !list_empty) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    is_dump_nxt   = is_dump_r;
    best_val_nxt  = best_val_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ctrl.mode     = CM_HOLD;
    ctrl.slot     = pos_m1;
    ctrl.value    = in_item.value;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (list_full) begin
                out_item_nxt = make_out(STS_FULL, '0, '0, POS_W'(count_r), 1'b1);
              end else if (in_item.position == '0 || pos_c > cnt_c + 1'b1) begin
                out_item_nxt = make_out(STS_BADPOS, '0, '0, POS_W'(count_r), 1'b1);
              end else begin
                ctrl.mode    = CM_INSERT;
                count_nxt    = count_r + 1'b1;
                out_item_nxt = make_out(STS_OK, in_item.position, in_item.value,
                                        POS_W'(count_nxt), 1'b1);
              end
            end
            OP_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (list_empty) begin
                out_item_nxt = make_out(STS_EMPTY, '0, '0, POS_W'(count_r), 1'b1);
              end else if (in_item.position == '0 || pos_c > cnt_c) begin
                out_item_nxt = make_out(STS_BADPOS, '0, '0, POS_W'(count_r), 1'b1);
              end else begin
                ctrl.mode    = CM_REMOVE;
                count_nxt    = count_r - 1'b1;
                out_item_nxt = make_out(STS_OK, in_item.position,
                                        cell_q[pos_m1[IDX_W-1:0]],
                                        POS_W'(count_nxt), 1'b1);
              end
            end
            OP_MAX, OP_DUMP: begin
              if (list_empty) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = make_out(STS_EMPTY, '0, '0, POS_W'(count_r), 1'b1);
              end else begin
                k_nxt       = '0;
                is_dump_nxt = (in_item.opcode == OP_DUMP);
              end
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_out(STS_OK, '0, '0, '0, 1'b1);
            end
            default: begin
              // Unused opcodes are consumed without a result.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (advance) begin
          ctrl.mode = CM_ROTATE;
          k_nxt     = k_r + 1'b1;
          if (in_range) begin
            if (is_dump_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_out(STS_OK, POS_W'(k_r) + 1'b1, cell_q[0],
                                       POS_W'(count_r), (k_ext == count_r - 1'b1));
            end else if (k_r == '0 || cell_q[0] >= best_val_r) begin
              // Equal values move the answer to the later position.
              best_val_nxt = cell_q[0];
              best_idx_nxt = k_r;
            end
          end
          if (scan_done && !is_dump_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = make_out(STS_OK, POS_W'(best_idx_nxt) + 1'b1,
                                     best_val_nxt, POS_W'(count_r), 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    is_dump_r  <= is_dump_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* sv/ple_checker.sv */
module ple_checker import ple_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != STS_OK |->
      out_item.last && out_item.result_position == '0 && out_item.result_value == '0)
    else $error("error result carries data or is not final");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STS_EMPTY |-> out_item.element_count == '0)
    else $error("empty status with nonzero element count");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.opcode == OP_CLEAR |=>
      out_valid && out_item.element_count == '0 && out_item.status == STS_OK)
    else $error("clear did not produce an empty ok result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ple_pkg::*;

  // The list size under test and the opcodes that the block must ignore.
  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Roughly how many meaningful commands the random part queues.
  localparam int RANDOM_CMDS = 500;

  // A dump walks the whole chain, and every result may sit behind a receiver
  // stall, so allow a generous number of cycles with no item moving at all.
  localparam int WATCHDOG_LIMIT = 40 * (LIST_DEPTH + 16);
  localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 8;

  typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_MASK} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  positional_list_engine #(.DEPTH(LIST_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Commands waiting to be sent, and the results that the list model says
  // the block owes us, oldest first.
  in_item_t  pending_cmds[$];
  out_item_t owed_results[$];

  // Our own copy of the list, updated as each item is accepted.
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int list_len = 0;

  // Length of the list as the command generator expects it to be once all
  // queued commands have run; used only to steer positions.
  int gen_len = 0;
  int cmds_queued = 0;

  int errors = 0;
  int cmds_accepted = 0;
  int results_checked = 0;
  int full_hits = 0;
  int dumps_walked = 0;
  int max_ties = 0;

  // Prints one line per mismatch (the first few dozen) and counts them all.
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  function automatic void owe_result(input status_t sts, input int pos,
                                     input logic signed [VAL_W-1:0] val,
                                     input bit fin);
    out_item_t r;
    r.status          = sts;
    r.result_position = pos[POS_W-1:0];
    r.result_value    = val;
    r.element_count   = list_len[POS_W-1:0];
    r.last            = fin;
    owed_results.push_back(r);
  endfunction

  // Applies one accepted command to the list copy and queues the results
  // that the block must produce for it. Errors leave the list untouched;
  // the full check precedes the position check on insert, and the empty
  // check precedes it on remove; find and dump check only for an empty list.
  task automatic apply_list_cmd(input in_item_t cmd);
    int p;
    int i;
    int best;
    logic signed [VAL_W-1:0] taken;
    p = int'(cmd.position);
    case (cmd.opcode)
      OP_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          full_hits++;
          owe_result(STS_FULL, 0, '0, 1'b1);
        end else if (p < 1 || p > list_len + 1) begin
          owe_result(STS_BADPOS, 0, '0, 1'b1);
        end else begin
          for (i = list_len; i >= p; i--) begin
            list_mem[i] = list_mem[i - 1];
          end
          list_mem[p - 1] = cmd.value;
          list_len++;
          owe_result(STS_OK, p, cmd.value, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (list_len == 0) begin
          owe_result(STS_EMPTY, 0, '0, 1'b1);
        end else if (p < 1 || p > list_len) begin
          owe_result(STS_BADPOS, 0, '0, 1'b1);
        end else begin
          taken = list_mem[p - 1];
          for (i = p; i < list_len; i++) begin
            list_mem[i - 1] = list_mem[i];
          end
          list_len--;
          owe_result(STS_OK, p, taken, 1'b1);
        end
      end
      OP_MAX: begin
        if (list_len == 0) begin
          owe_result(STS_EMPTY, 0, '0, 1'b1);
        end else begin
          // Equal values move the answer to the later position.
          best = 0;
          for (i = 1; i < list_len; i++) begin
            if (list_mem[i] == list_mem[best]) max_ties++;
            if (list_mem[i] >= list_mem[best]) best = i;
          end
          owe_result(STS_OK, best + 1, list_mem[best], 1'b1);
        end
      end
      OP_DUMP: begin
        if (list_len == 0) begin
          owe_result(STS_EMPTY, 0, '0, 1'b1);
        end else begin
          dumps_walked++;
          for (i = 0; i < list_len; i++) begin
            owe_result(STS_OK, i + 1, list_mem[i], i + 1 == list_len);
          end
        end
      end
      OP_CLEAR: begin
        list_len = 0;
        owe_result(STS_OK, 0, '0, 1'b1);
      end
      default: begin
        // The spare opcodes produce nothing and change nothing.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Command generation. Every queued insert, remove or clear also updates
  // gen_len so that later positions can be aimed inside or just outside the list.
  // ---------------------------------------------------------------------
  task automatic queue_cmd(input logic [2:0] op, input int pos,
                           input logic signed [VAL_W-1:0] val);
    in_item_t c;
    c.opcode   = op;
    c.position = pos[POS_W-1:0];
    c.value    = val;
    pending_cmds.push_back(c);
    case (op)
      OP_INSERT: begin
        if (gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
        cmds_queued++;
      end
      OP_REMOVE: begin
        if (gen_len > 0 && pos >= 1 && pos <= gen_len) gen_len--;
        cmds_queued++;
      end
      OP_CLEAR: begin
        gen_len = 0;
        cmds_queued++;
      end
      OP_MAX, OP_DUMP: cmds_queued++;
      default: begin
      end
    endcase
  endtask

  // Values lean toward the extremes and toward a few repeated numbers so
  // that ties for the maximum come up often.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return (int'($urandom_range(0, 4)) - 2) * 65536;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position, with the ends of the range favored; otherwise
  // zero or something past the end, up to the largest field value.
  function automatic int pick_position(input int top);
    int r;
    r = $urandom_range(0, 99);
    if (top >= 1 && r < 85) begin
      case ($urandom_range(0, 3))
        0: return 1;
        1: return top;
        default: return $urandom_range(1, top);
      endcase
    end
    if (r < 92) return 0;
    return $urandom_range(top + 1, (1 << POS_W) - 1);
  endfunction

  task automatic queue_random(input int ins_pct, input int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      queue_cmd(OP_INSERT, pick_position(gen_len + 1), pick_value());
    end else if (r < ins_pct + rem_pct) begin
      queue_cmd(OP_REMOVE, pick_position(gen_len), pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40)      queue_cmd(OP_MAX, $urandom_range(0, 63), $urandom);
      else if (r < 70) queue_cmd(OP_DUMP, $urandom_range(0, 63), $urandom);
      else if (r < 78) queue_cmd(OP_CLEAR, $urandom_range(0, 63), $urandom);
      else if (r < 90) queue_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                 $urandom_range(0, 63), $urandom);
      else if (r < 95) queue_cmd(OP_INSERT, $urandom_range(0, 63), $urandom);
      else             queue_cmd(OP_REMOVE, $urandom_range(0, 63), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender: takes items from pending_cmds in bursts of random length with
  // random gaps in between. Once valid is up it holds until accepted, and
  // the accepted item is handed to the list model on the same edge.
  // ---------------------------------------------------------------------
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_list_cmd(in_item);
        cmds_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_item  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A quarter of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: the stall pattern is redrawn at random among always ready,
  // a coin toss, one cycle in four, and a random eight-bit mask.
  // ---------------------------------------------------------------------
  rx_mode_t rx_mode = RX_FREE;
  logic [7:0] rx_mask = 8'hFF;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      rx_tick++;
      if (rx_tick % 96 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mask = 8'($urandom_range(0, 255)) | 8'h01;
      end
      case (rx_mode)
        RX_FREE: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_SLOW: out_ready <= (rx_tick[1:0] == 2'd0);
        default: out_ready <= rx_mask[rx_tick[2:0]];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every accepted result is checked field by field against the
  // oldest result still owed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result item %p arrived with none owed", out_item));
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d",
                                    out_item.status, want.status));
        if (out_item.result_position !== want.result_position)
          report_mismatch($sformatf("result_position %0d, wanted %0d",
                                    out_item.result_position, want.result_position));
        if (out_item.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %h, wanted %h",
                                    out_item.result_value, want.result_value));
        if (out_item.element_count !== want.element_count)
          report_mismatch($sformatf("element_count %0d, wanted %0d",
                                    out_item.element_count, want.element_count));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b", out_item.last, want.last));
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side
  // means the block has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    // Directed opening: every command on an empty list, inserts at head,
    // tail and out of range, a tie for the maximum at a later position,
    // removes at both ends and out of range, the spare opcodes (two of them
    // with every bit set), and clears on non-empty and empty lists.
    queue_cmd(OP_DUMP, 0, '0);
    queue_cmd(OP_MAX, 0, '0);
    queue_cmd(OP_REMOVE, 1, '0);
    queue_cmd(OP_INSERT, 0, 32'sd5);
    queue_cmd(OP_INSERT, 2, 32'sd5);
    queue_cmd(OP_INSERT, 1, 32'sh7FFF_FFFF);
    queue_cmd(OP_INSERT, 2, 32'sh8000_0000);
    queue_cmd(OP_INSERT, 1, 32'sd0);
    queue_cmd(OP_INSERT, 4, 32'sh7FFF_FFFF);
    queue_cmd(OP_MAX, 0, '0);
    queue_cmd(OP_INSERT, 63, -32'sd1);
    queue_cmd(OP_DUMP, 63, -32'sd1);
    queue_cmd(OP_REMOVE, 0, '0);
    queue_cmd(OP_REMOVE, 5, '0);
    queue_cmd(OP_REMOVE, 1, '0);
    queue_cmd(OP_REMOVE, 3, '0);
    queue_cmd(OP_MAX, 0, '0);
    queue_cmd(OP_UNUSED_LO, 63, -32'sd1);
    queue_cmd(OP_UNUSED_LO + 3'd1, 1, '0);
    queue_cmd(OP_UNUSED_HI, 63, -32'sd1);
    queue_cmd(OP_CLEAR, 63, -32'sd1);
    queue_cmd(OP_DUMP, 0, '0);
    queue_cmd(OP_CLEAR, 0, '0);
    queue_cmd(OP_INSERT, 1, -32'sd1);
    queue_cmd(OP_DUMP, 0, '0);

    // Random part in phases: fill the list to the top and push against it,
    // drain it to empty and keep pulling, or mix everything at a steady level.
    while (cmds_queued < RANDOM_CMDS) begin
      case ($urandom_range(0, 2))
        0: begin
          while (gen_len < LIST_DEPTH) queue_random(90, 2);
          repeat ($urandom_range(2, 4)) queue_random(100, 0);
          queue_cmd(OP_MAX, 0, '0);
          queue_cmd(OP_DUMP, 0, '0);
        end
        1: begin
          while (gen_len > 0) queue_random(10, 80);
          repeat ($urandom_range(1, 3)) queue_random(0, 100);
        end
        default: begin
          repeat (40) queue_random(45, 35);
        end
      endcase
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    // Let a walk that might still be running show any stray results.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (owed_results.size() != 0)
      report_mismatch($sformatf("%0d owed results never arrived", owed_results.size()));

    $display("Sent %0d list commands: %0d dumps of a non-empty list, %0d inserts into a full list.",
             cmds_accepted, dumps_walked, full_hits);
    $display("Compared %0d result items; %0d equal pairs met during maximum searches.",
             results_checked, max_ties);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
